### rtl/core/quaternion_to_euler_degrees_assert.svh
// Assertion macros for the quaternion to Euler angle block.
// Used by the top level; no other dependencies.
`ifndef QUATERNION_TO_EULER_DEGREES_ASSERT_SVH
`define QUATERNION_TO_EULER_DEGREES_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, active also in reset
`define ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, ante, cons)
`endif
`endif

### rtl/core/qte_pkg.sv
// Shared widths, types and the arctangent table of the quaternion to Euler block.
// No dependencies.
package qte_pkg;

    localparam int OPW            = 35;  // atan2 operand width, |value| <= 2^32
    localparam int CW             = 45;  // rotation cell datapath width
    localparam int MAG_W          = 34;
    localparam int NORM_TOP       = 41;  // normalized magnitude lies in [2^40, 2^41)
    localparam int SQRT_CELLS     = 32;
    localparam int ATAN_TABLE_LEN = 24;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    typedef logic signed [OPW-1:0] op_t;
    typedef logic signed [CW-1:0]  cw_t;

    typedef struct packed {
        op_t         p_term;
        op_t         q_term;
        op_t         r_term;
        op_t         t_term;
        op_t         ys_term;
        logic        yaw_ovr;
        logic [31:0] yaw_ovr_ang;
        logic        zero_q;
    } side_t;

    typedef struct packed {
        logic        both_zero;
        logic        ovr;
        logic [31:0] ovr_ang;
    } lane_flag_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/quaternion_to_euler_degrees.sv
// Top level: quaternion in, pitch/yaw/roll in fractional degrees out.
// Depends on qte_pkg, qte_sqrt_cell, qte_atan2_lane and the assertion header.
//
//  channel | direction | tdata (low bit up)                    | tuser
//  s_      | in        | quat_x, quat_y, quat_z, quat_w        | -
//  m_      | out       | pitch_angle, yaw_angle, roll_angle    | zero_quaternion
//
// One item per cycle while the output is not stalled; five product/sum
// stages, 32 square-root cells and CORDIC_STAGES + 3 stages in each atan2 lane.
// A stalled output freezes the whole pipeline, so no item is dropped.
// Reset clears the valid bits only.
`include "quaternion_to_euler_degrees_assert.svh"
module quaternion_to_euler_degrees #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((3*(9+ANGLE_FRAC_BITS)+7)/8)*8-1:0] m_tdata,
                                   // pitch_angle, yaw_angle, roll_angle, zero pad
    output logic [0:0]  m_tuser    // zero_quaternion
);
    import qte_pkg::*;

    localparam int            AW        = 9 + ANGLE_FRAC_BITS;
    localparam int            TDW       = ((3 * AW + 7) / 8) * 8;
    localparam int            LANE_LAT  = CORDIC_STAGES + 3;
    localparam int            PRE_LAT   = 5;
    localparam int            TOTAL     = PRE_LAT + SQRT_CELLS + LANE_LAT;
    localparam logic [AW-1:0] FULL_TURN = AW'(360 << ANGLE_FRAC_BITS);

    logic             en;
    logic [TOTAL-1:0] vld_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[TOTAL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOTAL-2:0], s_tvalid};
        end
    end

    // products
    logic signed [15:0] qx, qy, qz, qw;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0] wx_reg, yz_reg, wy_reg, zx_reg, wz_reg, xy_reg;

    assign qx = s_tdata[15:0];
    assign qy = s_tdata[31:16];
    assign qz = s_tdata[47:32];
    assign qw = s_tdata[63:48];

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            ww_reg <= qw * qw;
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
        end
    end

    // sums, all scaled by the squared norm
    logic [32:0] n_next, n_reg;
    op_t         p_reg, q_reg, s_reg, r_reg, t_reg;
    logic        zero_reg;

    assign n_next = 33'(xx_reg) + 33'(yy_reg) + 33'(zz_reg) + 33'(ww_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg    <= n_next;
            p_reg    <= (op_t'(wx_reg) + op_t'(yz_reg)) <<< 1;
            q_reg    <= op_t'(n_next) - ((op_t'(xx_reg) + op_t'(yy_reg)) <<< 1);
            s_reg    <= (op_t'(wy_reg) - op_t'(zx_reg)) <<< 1;
            r_reg    <= (op_t'(wz_reg) + op_t'(xy_reg)) <<< 1;
            t_reg    <= op_t'(n_next) - ((op_t'(yy_reg) + op_t'(zz_reg)) <<< 1);
            zero_reg <= (n_next == '0);
        end
    end

    // yaw preparation: saturate, or halve the terms when the norm has 33 bits
    op_t         s_abs;
    logic [32:0] a_mag;
    logic        half;
    logic [31:0] nn_c, ah_c;
    logic        s_pos, sat;
    side_t       side_c;
    logic [31:0] nn_reg, ah_reg;
    side_t       side_c_reg;

    always_comb begin
        s_abs = s_reg[OPW-1] ? -s_reg : s_reg;
        a_mag = s_abs[32:0];
        sat   = (a_mag >= n_reg);
        half  = n_reg[32];
        nn_c  = half ? n_reg[32:1] : n_reg[31:0];
        ah_c  = half ? a_mag[32:1] : a_mag[31:0];
        s_pos = !s_reg[OPW-1] && (s_reg != '0);
        side_c.p_term      = p_reg;
        side_c.q_term      = q_reg;
        side_c.r_term      = r_reg;
        side_c.t_term      = t_reg;
        side_c.ys_term     = s_reg[OPW-1] ? -op_t'(ah_c) : op_t'(ah_c);
        side_c.yaw_ovr     = sat || zero_reg;
        side_c.yaw_ovr_ang = zero_reg ? 32'h0 :
                             (s_pos ? QUARTER_TURN : 32'h0 - QUARTER_TURN);
        side_c.zero_q      = zero_reg;
    end

    logic [63:0] nsq_reg, asq_reg, rad_reg;
    side_t       side_d_reg, side_e_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nn_reg     <= nn_c;
            ah_reg     <= ah_c;
            side_c_reg <= side_c;
            nsq_reg    <= 64'(nn_reg) * 64'(nn_reg);
            asq_reg    <= 64'(ah_reg) * 64'(ah_reg);
            side_d_reg <= side_c_reg;
            rad_reg    <= nsq_reg - asq_reg;
            side_e_reg <= side_d_reg;
        end
    end

    // square root chain
    logic [63:0] rem  [0:SQRT_CELLS];
    logic [63:0] root [0:SQRT_CELLS];
    side_t       side [0:SQRT_CELLS];

    assign rem[0]  = rad_reg;
    assign root[0] = '0;
    assign side[0] = side_e_reg;

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        qte_sqrt_cell #(.IDX(k)) u_sqrt (
            .aclk     (aclk),
            .en       (en),
            .rem_in   (rem[k]),
            .root_in  (root[k]),
            .side_in  (side[k]),
            .rem_out  (rem[k+1]),
            .root_out (root[k+1]),
            .side_out (side[k+1])
        );
    end

    side_t sq_side;
    op_t   yaw_x;

    assign sq_side = side[SQRT_CELLS];
    assign yaw_x   = op_t'(root[SQRT_CELLS][31:0]);

    // angle lanes
    logic [AW-1:0] pitch_out, yaw_out, roll_out;

    qte_atan2_lane #(.STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS)) u_pitch (
        .aclk       (aclk),
        .en         (en),
        .y_in       (sq_side.p_term),
        .x_in       (sq_side.q_term),
        .ovr_in     (1'b0),
        .ovr_ang_in (32'h0),
        .angle_out  (pitch_out)
    );

    qte_atan2_lane #(.STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS)) u_yaw (
        .aclk       (aclk),
        .en         (en),
        .y_in       (sq_side.ys_term),
        .x_in       (yaw_x),
        .ovr_in     (sq_side.yaw_ovr),
        .ovr_ang_in (sq_side.yaw_ovr_ang),
        .angle_out  (yaw_out)
    );

    qte_atan2_lane #(.STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS)) u_roll (
        .aclk       (aclk),
        .en         (en),
        .y_in       (sq_side.r_term),
        .x_in       (sq_side.t_term),
        .ovr_in     (1'b0),
        .ovr_ang_in (32'h0),
        .angle_out  (roll_out)
    );

    // carry the zero flag alongside the lanes
    logic zd_reg [0:LANE_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            zd_reg[0] <= sq_side.zero_q;
            for (int k = 1; k < LANE_LAT; k++) begin
                zd_reg[k] <= zd_reg[k-1];
            end
        end
    end

    assign m_tdata    = TDW'({roll_out, yaw_out, pitch_out});
    assign m_tuser[0] = zd_reg[LANE_LAT-1];

    // remainder of the root chain is not needed
    logic unused_rem;
    assign unused_rem = ^rem[SQRT_CELLS] ^ ^root[SQRT_CELLS][63:32];

    `ASSERT_IMPL(a_zero_angles, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    `ASSERT_IMPL(a_angle_range, aclk, aresetn, m_tvalid,
                 (pitch_out < FULL_TURN) && (yaw_out < FULL_TURN) && (roll_out < FULL_TURN))
    `ASSERT_IMPL(a_stall_blocks_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid)
endmodule

### rtl/core/qte_sqrt_cell.sv
// One digit step of the integer square root chain; carries the item's side data along.
// Depends on qte_pkg.
module qte_sqrt_cell #(
    parameter int IDX = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [63:0]    rem_in,
    input  logic [63:0]    root_in,
    input  qte_pkg::side_t side_in,
    output logic [63:0]    rem_out,
    output logic [63:0]    root_out,
    output qte_pkg::side_t side_out
);
    import qte_pkg::*;

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

    logic [63:0] trial;
    logic        take;
    logic [63:0] rem_reg, rem_next, root_reg, root_next;
    side_t       side_reg;

    always_comb begin
        trial     = root_in + BIT;
        take      = (rem_in >= trial);
        rem_next  = take ? rem_in - trial : rem_in;
        root_next = take ? (root_in >> 1) + BIT : root_in >> 1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;
endmodule

### rtl/core/qte_cordic_cell.sv
// One vectoring rotation step of the atan2 chain.
// Depends on qte_pkg for widths and the arctangent table.
module qte_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic         aclk,
    input  logic         en,
    input  qte_pkg::cw_t x_in,
    input  qte_pkg::cw_t y_in,
    input  logic [31:0]  ang_in,
    output qte_pkg::cw_t x_out,
    output qte_pkg::cw_t y_out,
    output logic [31:0]  ang_out
);
    import qte_pkg::*;

    localparam logic [31:0] ATAN = atan_turn(IDX);

    logic        rot_pos;
    cw_t         x_reg, x_next, y_reg, y_next;
    logic [31:0] ang_reg, ang_next;

    always_comb begin
        rot_pos = !y_in[CW-1] && (y_in != '0);
        if (rot_pos) begin
            x_next   = x_in + (y_in >>> IDX);
            y_next   = y_in - (x_in >>> IDX);
            ang_next = ang_in + ATAN;
        end else begin
            x_next   = x_in - (y_in >>> IDX);
            y_next   = y_in + (x_in >>> IDX);
            ang_next = ang_in - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang_next;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign ang_out = ang_reg;
endmodule

### rtl/core/qte_atan2_lane.sv
// atan2 lane: half-plane pre-rotation, normalize, a row of rotation cells, degree scaling.
// Depends on qte_pkg and qte_cordic_cell.
module qte_atan2_lane #(
    parameter int STAGES = 16,
    parameter int FRAC   = 6
) (
    input  logic              aclk,
    input  logic              en,
    input  qte_pkg::op_t      y_in,
    input  qte_pkg::op_t      x_in,
    input  logic              ovr_in,
    input  logic [31:0]       ovr_ang_in,
    output logic [9+FRAC-1:0] angle_out
);
    import qte_pkg::*;

    localparam int          AW         = 9 + FRAC;
    localparam logic [63:0] UNIT_SCALE = 64'd360 << FRAC;

    // pre-rotation
    op_t              rx, ry;
    logic [31:0]      ang0;
    logic [MAG_W-1:0] ax, ay;
    op_t              x0_reg, y0_reg;
    logic [MAG_W-1:0] mag0_reg;
    logic [31:0]      ang0_reg;
    lane_flag_t       fl_reg [0:STAGES+1];

    always_comb begin
        rx   = x_in;
        ry   = y_in;
        ang0 = '0;
        if (x_in[OPW-1]) begin
            if (!y_in[OPW-1]) begin
                rx   = y_in;
                ry   = -x_in;
                ang0 = QUARTER_TURN;
            end else begin
                rx   = -y_in;
                ry   = x_in;
                ang0 = 32'h0 - QUARTER_TURN;
            end
        end
        ax = MAG_W'(rx);
        ay = ry[OPW-1] ? MAG_W'(-ry) : MAG_W'(ry);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg              <= rx;
            y0_reg              <= ry;
            mag0_reg            <= (ax > ay) ? ax : ay;
            ang0_reg            <= ang0;
            fl_reg[0].both_zero <= (x_in == '0) && (y_in == '0);
            fl_reg[0].ovr       <= ovr_in;
            fl_reg[0].ovr_ang   <= ovr_ang_in;
            for (int k = 1; k <= STAGES + 1; k++) begin
                fl_reg[k] <= fl_reg[k-1];
            end
        end
    end

    // normalize: shift until the larger magnitude reaches bit 40
    logic [NORM_TOP-1:0] mm;
    logic [5:0]          sh;
    cw_t                 x1_reg, y1_reg;
    logic [31:0]         ang1_reg;

    always_comb begin
        mm = NORM_TOP'(mag0_reg);
        sh = '0;
        for (int k = 5; k >= 0; k--) begin
            if (mm < (NORM_TOP'(1) << (NORM_TOP - (1 << k)))) begin
                mm = mm << (1 << k);
                sh = sh | 6'(1 << k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg   <= CW'(x0_reg) <<< sh;
            y1_reg   <= CW'(y0_reg) <<< sh;
            ang1_reg <= ang0_reg;
        end
    end

    // rotation cells
    cw_t         cx [0:STAGES];
    cw_t         cy [0:STAGES];
    logic [31:0] ca [0:STAGES];

    assign cx[0] = x1_reg;
    assign cy[0] = y1_reg;
    assign ca[0] = ang1_reg;

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        qte_cordic_cell #(.IDX(i)) u_cell (
            .aclk    (aclk),
            .en      (en),
            .x_in    (cx[i]),
            .y_in    (cy[i]),
            .ang_in  (ca[i]),
            .x_out   (cx[i+1]),
            .y_out   (cy[i+1]),
            .ang_out (ca[i+1])
        );
    end

    // scale the binary angle to fractional degrees
    logic [31:0]   fin_ang;
    logic [63:0]   prod;
    logic [AW-1:0] angle_reg;

    always_comb begin
        if (fl_reg[STAGES+1].ovr) begin
            fin_ang = fl_reg[STAGES+1].ovr_ang;
        end else if (fl_reg[STAGES+1].both_zero) begin
            fin_ang = '0;
        end else begin
            fin_ang = ca[STAGES];
        end
        prod = 64'(fin_ang) * UNIT_SCALE;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= prod[32 +: AW];
        end
    end

    assign angle_out = angle_reg;
    // cx/cy of the last cell feed nothing further
    logic unused_tail;
    assign unused_tail = ^{cx[STAGES], cy[STAGES]};
endmodule
